/* rtl/core/pis_pkg.sv */
// Shared types, constants and the control program of the PI speed-loop block.
// Used by pis_sequencer, pis_datapath and pid_integral_separation_unit.
package pis_pkg;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_PROP_GAIN      = 3'd0;
    localparam logic [2:0] REG_INTEG_GAIN     = 3'd1;
    localparam logic [2:0] REG_INTEGRAL_LIMIT = 3'd2;
    localparam logic [2:0] REG_BAND_ONE       = 3'd3;
    localparam logic [2:0] REG_BAND_TWO       = 3'd4;
    localparam logic [2:0] REG_BAND_THREE     = 3'd5;
    localparam logic [2:0] REG_BAND_FOUR      = 3'd6;
    localparam logic [2:0] REG_BAND_FIVE      = 3'd7;

    // Reset values of the registers.
    localparam logic [15:0] RST_PROP_GAIN      = 16'd307;
    localparam logic [15:0] RST_INTEG_GAIN     = 16'd0;
    localparam logic [14:0] RST_INTEGRAL_LIMIT = 15'd540;
    localparam logic [15:0] RST_BAND_ONE       = 16'd10;
    localparam logic [15:0] RST_BAND_TWO       = 16'd50;
    localparam logic [15:0] RST_BAND_THREE     = 16'd90;
    localparam logic [15:0] RST_BAND_FOUR      = 16'd120;
    localparam logic [15:0] RST_BAND_FIVE      = 16'd300;

    localparam int NUM_BANDS = 5;
    localparam logic [2:0] BAND_OUTSIDE = 3'd5;

    // Largest magnitude the integral can reach.
    localparam int INTEGRAL_MAX = 98301;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [15:0]                prop_gain;
        logic [15:0]                integ_gain;
        logic [14:0]                integral_limit;
        logic [NUM_BANDS-1:0][15:0] band;
    } pis_cfg_t;

    // Datapath operations.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_BAND,
        OP_INTEG,
        OP_MUL_I,
        OP_MUL_P,
        OP_SUM
    } op_t;

    // Jump conditions; a wait condition also holds back the operation.
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_BAND_HIT,
        COND_OUT_BUSY
    } cond_t;

    localparam int STEP_W = 4;

    // One control word of the program.
    typedef struct packed {
        op_t               op;
        logic [2:0]        band_sel;
        cond_t             cond;
        logic [STEP_W-1:0] target;
        logic              seq_end;
    } ucode_t;

    // Control handed from the sequencer to the datapath.
    typedef struct packed {
        op_t        op;
        logic [2:0] band_sel;
        logic       fire;
    } pis_ctrl_t;

    // Status handed from the datapath back to the sequencer.
    typedef struct packed {
        logic in_valid;
        logic band_hit;
        logic out_busy;
    } pis_status_t;

    // The control program. Step 0 takes an input, steps 1 to 5 test the
    // bands innermost first, then the integral update and three multiply
    // and sum steps follow.
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        w = '{op: OP_NOP, band_sel: 3'd0, cond: COND_ALWAYS, target: '0, seq_end: 1'b0};
        case (step)
            4'd0: w = '{op: OP_LOAD,  band_sel: 3'd0, cond: COND_NO_INPUT,
                        target: 4'd0, seq_end: 1'b0};
            4'd1: w = '{op: OP_BAND,  band_sel: 3'd0, cond: COND_BAND_HIT,
                        target: 4'd6, seq_end: 1'b0};
            4'd2: w = '{op: OP_BAND,  band_sel: 3'd1, cond: COND_BAND_HIT,
                        target: 4'd6, seq_end: 1'b0};
            4'd3: w = '{op: OP_BAND,  band_sel: 3'd2, cond: COND_BAND_HIT,
                        target: 4'd6, seq_end: 1'b0};
            4'd4: w = '{op: OP_BAND,  band_sel: 3'd3, cond: COND_BAND_HIT,
                        target: 4'd6, seq_end: 1'b0};
            4'd5: w = '{op: OP_BAND,  band_sel: 3'd4, cond: COND_NEVER,
                        target: 4'd0, seq_end: 1'b0};
            4'd6: w = '{op: OP_INTEG, band_sel: 3'd0, cond: COND_NEVER,
                        target: 4'd0, seq_end: 1'b0};
            4'd7: w = '{op: OP_MUL_I, band_sel: 3'd0, cond: COND_NEVER,
                        target: 4'd0, seq_end: 1'b0};
            4'd8: w = '{op: OP_MUL_P, band_sel: 3'd0, cond: COND_NEVER,
                        target: 4'd0, seq_end: 1'b0};
            4'd9: w = '{op: OP_SUM,   band_sel: 3'd0, cond: COND_OUT_BUSY,
                        target: 4'd9, seq_end: 1'b1};
            default: w = '{op: OP_NOP, band_sel: 3'd0, cond: COND_ALWAYS,
                           target: 4'd0, seq_end: 1'b0};
        endcase
        return w;
    endfunction

    // Integral weights in unsigned Q1.8, by band.
    function automatic logic [8:0] weight_q8(input logic [2:0] band);
        logic [8:0] w;
        case (band)
            3'd0:    w = 9'd256;
            3'd1:    w = 9'd205;
            3'd2:    w = 9'd154;
            3'd3:    w = 9'd102;
            3'd4:    w = 9'd51;
            default: w = 9'd0;
        endcase
        return w;
    endfunction

endpackage

/* rtl/core/pis_sequencer.sv */
// Step counter and program lookup of the PI speed-loop block.
// Depends on pis_pkg for the control program and the control structs.
module pis_sequencer
    import pis_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  pis_status_t status,
    output pis_ctrl_t   ctrl
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    ucode_t            word;
    logic              cond_true;
    logic              waiting;

    // Current control word.
    assign word = ucode_rom(step_reg);

    // Evaluate the jump condition of this step.
    always_comb begin
        unique case (word.cond)
            COND_NEVER:    cond_true = 1'b0;
            COND_ALWAYS:   cond_true = 1'b1;
            COND_NO_INPUT: cond_true = !status.in_valid;
            COND_BAND_HIT: cond_true = status.band_hit;
            COND_OUT_BUSY: cond_true = status.out_busy;
            default:       cond_true = 1'b0;
        endcase
    end

    // A step that waits on input or on the output register does nothing.
    assign waiting = cond_true &&
                     (word.cond == COND_NO_INPUT || word.cond == COND_OUT_BUSY);

    assign ctrl.op       = word.op;
    assign ctrl.band_sel = word.band_sel;
    assign ctrl.fire     = !waiting;

    // Next step: jump, restart at the end, or advance.
    always_comb begin
        if (cond_true) begin
            step_next = word.target;
        end else if (word.seq_end) begin
            step_next = '0;
        end else begin
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else begin
            step_reg <= step_next;
        end
    end

    // The program has ten steps; the counter never leaves them.
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= 4'd9)
        else $error("step counter left the program");

    // A band hit always lands on the integral update.
    a_band_jump: assert property (@(posedge aclk) disable iff (!aresetn)
        (word.op == OP_BAND && status.band_hit) |=> (step_reg == 4'd6))
        else $error("band hit did not reach the integral step");

    // A finished sum returns to the input step.
    a_sum_return: assert property (@(posedge aclk) disable iff (!aresetn)
        (word.op == OP_SUM && !status.out_busy) |=> (step_reg == 4'd0))
        else $error("sequencer did not return after the sum");

endmodule

/* rtl/core/pis_datapath.sv */
// Datapath of the PI speed-loop block: error, band, integral, shared multiplier
// and output register. Depends on pis_pkg and is driven by pis_sequencer.
module pis_datapath
    import pis_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  pis_cfg_t           cfg,
    input  pis_ctrl_t          ctrl,
    input  logic signed [15:0] target_speed,
    input  logic signed [15:0] measured_speed,
    input  logic               s_tvalid,
    input  logic               m_tready,
    output pis_status_t        status,
    output logic               out_valid,
    output logic signed [31:0] drive_value,
    output logic [2:0]         error_band,
    output logic signed [17:0] integral_now
);

    logic signed [16:0] err_reg;
    logic [16:0]        mag_reg;
    logic [2:0]         band_reg;
    logic signed [17:0] integral_reg;
    logic signed [43:0] prod_reg;
    logic signed [26:0] iterm_reg;
    logic signed [31:0] drive_reg;
    logic               out_valid_reg;

    logic signed [16:0] err_next;
    logic [16:0]        mag_next;
    logic signed [17:0] integral_next;
    logic signed [17:0] lim;
    logic signed [17:0] neg_lim;
    logic signed [18:0] int_add;
    logic               at_upper;
    logic               at_lower;
    logic signed [25:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [43:0] mul_p;
    logic signed [24:0] pterm;
    logic signed [33:0] sum;
    logic signed [31:0] sum_sat;
    logic               band_hit;
    logic               out_busy;

    // Error and its magnitude, from a new input transaction.
    assign err_next = 17'(measured_speed) - 17'(target_speed);
    assign mag_next = err_next[16] ? 17'(-err_next) : 17'(err_next);

    // Band test of the currently selected threshold.
    assign band_hit = (ctrl.op == OP_BAND) && (mag_reg < {1'b0, cfg.band[ctrl.band_sel]});

    // Integral update with separation clamp.
    assign lim      = $signed({3'b000, cfg.integral_limit});
    assign neg_lim  = -lim;
    assign int_add  = 19'(integral_reg) + 19'(err_reg);
    assign at_upper = integral_reg >= lim;
    assign at_lower = !at_upper && (integral_reg <= neg_lim);

    always_comb begin
        if (at_upper) begin
            integral_next = err_reg[16] ? int_add[17:0] : lim;
        end else if (at_lower) begin
            integral_next = (!err_reg[16] && err_reg != 17'sd0) ? int_add[17:0] : neg_lim;
        end else begin
            integral_next = int_add[17:0];
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        case (ctrl.op)
            OP_INTEG: begin
                mul_a = $signed({10'd0, cfg.integ_gain});
                mul_b = $signed({9'd0, weight_q8(band_reg)});
            end
            OP_MUL_I: begin
                mul_a = $signed({1'b0, prod_reg[24:0]});
                mul_b = integral_reg;
            end
            default: begin
                mul_a = $signed({10'd0, cfg.prop_gain});
                mul_b = 18'(err_reg);
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Final sum of both terms with saturation to 32 bits.
    assign pterm = prod_reg[32:8];
    assign sum   = 34'(iterm_reg) + 34'(pterm);

    always_comb begin
        if (sum > 34'sd2147483647) begin
            sum_sat = 32'sh7fffffff;
        end else if (sum < -34'sd2147483648) begin
            sum_sat = 32'sh80000000;
        end else begin
            sum_sat = sum[31:0];
        end
    end

    assign out_busy = out_valid_reg && !m_tready;

    // Control state: integral and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integral_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (ctrl.op == OP_INTEG) begin
                integral_reg <= integral_next;
            end
            if (ctrl.op == OP_SUM && ctrl.fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        case (ctrl.op)
            OP_LOAD: begin
                if (s_tvalid) begin
                    err_reg  <= err_next;
                    mag_reg  <= mag_next;
                    band_reg <= BAND_OUTSIDE;
                end
            end
            OP_BAND: begin
                if (band_hit) begin
                    band_reg <= ctrl.band_sel;
                end
            end
            OP_INTEG: begin
                prod_reg <= mul_p;
            end
            OP_MUL_I: begin
                prod_reg <= mul_p;
            end
            OP_MUL_P: begin
                iterm_reg <= prod_reg[42:16];
                prod_reg  <= mul_p;
            end
            OP_SUM: begin
                if (ctrl.fire) begin
                    drive_reg    <= sum_sat;
                    error_band   <= band_reg;
                    integral_now <= integral_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign status.in_valid = s_tvalid;
    assign status.band_hit = band_hit;
    assign status.out_busy = out_busy;
    assign out_valid       = out_valid_reg;
    assign drive_value     = drive_reg;

    // The integral never leaves the range the clamp allows.
    a_integral_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (integral_reg <= 18'sd98301) && (integral_reg >= -18'sd98301))
        else $error("integral out of range");

    // A sum step that fires leaves a valid result behind.
    a_sum_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == OP_SUM && ctrl.fire) |=> out_valid_reg)
        else $error("sum step did not present a result");

    // A held result is never overwritten by a sum step.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_busy |-> !(ctrl.op == OP_SUM && ctrl.fire))
        else $error("result overwritten while stalled");

endmodule

/* rtl/core/pid_integral_separation_unit.sv */
// Top level of the PI speed-loop controller with integral separation and clamp.
// Depends on pis_pkg, pis_sequencer and pis_datapath.
//
// Usage:
//   s_ channel: one transaction carries target_speed (s_tdata[15:0]) and
//   measured_speed (s_tdata[31:16]), both signed. s_tready is high only in
//   the input step of the control program.
//   m_ channel: one transaction per input with drive_value, error_band and
//   integral_now packed in m_tdata.
//   Configuration: cfg_wr_en with cfg_index and cfg_wdata writes one of the
//   eight gain, limit and band registers; write only while the block is idle.
// Timing: after its input is accepted, an item passes through one to
//   five band compares (the first threshold that hits ends the search),
//   the integral update and three steps through the single shared 26 by 18
//   bit multiplier and the final adder. A new item is taken only after the
//   sum step of the last; the input step opens as its result turns valid.
// Reset: aresetn low loads the register reset values, clears the integral
//   and the output valid, and returns the program to its input step.
// Stall: a result waits in the output register while m_tready is low; the
//   next item is taken and worked on, and its sum step waits for the slot.
module pid_integral_separation_unit
    import pis_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Input transactions: fields from bit 0 up: target_speed, measured_speed.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // Result transactions: fields from bit 0 up: drive_value[31:0],
    // error_band[34:32], integral_now[52:35], zero fill [55:53].
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,
    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    pis_cfg_t           cfg_reg;
    pis_ctrl_t          ctrl;
    pis_status_t        status;
    logic signed [31:0] drive_value;
    logic [2:0]         error_band;
    logic signed [17:0] integral_now;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prop_gain      <= RST_PROP_GAIN;
            cfg_reg.integ_gain     <= RST_INTEG_GAIN;
            cfg_reg.integral_limit <= RST_INTEGRAL_LIMIT;
            cfg_reg.band[0]        <= RST_BAND_ONE;
            cfg_reg.band[1]        <= RST_BAND_TWO;
            cfg_reg.band[2]        <= RST_BAND_THREE;
            cfg_reg.band[3]        <= RST_BAND_FOUR;
            cfg_reg.band[4]        <= RST_BAND_FIVE;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_PROP_GAIN:      cfg_reg.prop_gain      <= cfg_wdata;
                REG_INTEG_GAIN:     cfg_reg.integ_gain     <= cfg_wdata;
                REG_INTEGRAL_LIMIT: cfg_reg.integral_limit <= cfg_wdata[14:0];
                REG_BAND_ONE:       cfg_reg.band[0]        <= cfg_wdata;
                REG_BAND_TWO:       cfg_reg.band[1]        <= cfg_wdata;
                REG_BAND_THREE:     cfg_reg.band[2]        <= cfg_wdata;
                REG_BAND_FOUR:      cfg_reg.band[3]        <= cfg_wdata;
                REG_BAND_FIVE:      cfg_reg.band[4]        <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Program sequencer.
    pis_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    // Datapath.
    pis_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .ctrl           (ctrl),
        .target_speed   (s_tdata[15:0]),
        .measured_speed (s_tdata[31:16]),
        .s_tvalid       (s_tvalid),
        .m_tready       (m_tready),
        .status         (status),
        .out_valid      (m_tvalid),
        .drive_value    (drive_value),
        .error_band     (error_band),
        .integral_now   (integral_now)
    );

    // Input is taken only in the input step.
    assign s_tready = (ctrl.op == OP_LOAD);

    // Result packing.
    assign m_tdata = {3'b000, integral_now, error_band, drive_value};

endmodule
